// ----- rtl/pid_speed_controller_macros.svh -----
// Assertion macros shared by the PID speed controller modules.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef PID_SPEED_CONTROLLER_MACROS_SVH
`define PID_SPEED_CONTROLLER_MACROS_SVH
`ifndef SYNTH
// Antecedent and consequent in the same cycle.
`define PIDSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define PIDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PIDSC_ASSERT_NOW(lbl, ante, cons, msg)
`define PIDSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/pidsc_pkg.sv -----
// Shared constants and types of the PID speed controller.
// Used by pidsc_integrator and pid_speed_controller; depends on nothing.
package pidsc_pkg;

	localparam int SUM_WIDTH  = 40;
	localparam int SPEED_W    = 16;
	localparam int GAIN_W     = 24;
	localparam int LIMIT_W    = 16;
	localparam int ERR_W      = 18;
	localparam int DIFF_W     = 19;
	localparam int FRAC_W     = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 24;

	// The integral magnitude is multiplied in two halves.
	localparam int HALF_W = (SUM_WIDTH + 1) / 2;
	localparam int HIGH_W = SUM_WIDTH - HALF_W;
	localparam int PROD_W = SUM_WIDTH + GAIN_W;
	localparam int P_W    = ERR_W + GAIN_W;
	localparam int D_W    = DIFF_W + GAIN_W;
	localparam int PD_W   = D_W + 1;
	// A term magnitude is capped at 2^60, which needs 61 bits.
	localparam int CAP_W  = 61;
	localparam int WIDE_W = (PROD_W > CAP_W) ? PROD_W : CAP_W;
	localparam int TOT_W  = 64;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_GAIN_P   = 2'd0,
		REG_GAIN_I   = 2'd1,
		REG_GAIN_D   = 2'd2,
		REG_PWM_LIMIT = 2'd3
	} cfg_reg_t;

	// Result of the accumulate stage; all fields are two's complement.
	typedef struct packed {
		logic [ERR_W-1:0]     error;
		logic [DIFF_W-1:0]    diff;
		logic [SUM_WIDTH-1:0] sum;
	} acc_res_t;

endpackage

// ----- rtl/pid_speed_controller.sv -----
// PID speed controller top level: configuration registers, product and clamp pipeline.
// Depends on pidsc_pkg, pidsc_integrator and pid_speed_controller_macros.svh.
//
// Each slave transaction is one control tick and yields exactly one master transaction,
// in order. The block takes one tick per clock cycle unless the output stalls; a result
// is registered through each stage after its tick is accepted, and the only loop is the
// integral and previous-error update in the first stage. Gains are unsigned Q8.16; the
// drive value is truncated toward zero and clamped to 0..pwm_limit, and tuser flags a
// clamped value. Write the configuration only while no tick is in flight.
`include "pid_speed_controller_macros.svh"

module pid_speed_controller import pidsc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [15:0] speed_set, [31:16] measured_speed
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [15:0] pwm_duty
	output logic                  m_tuser    // [0] clamped
);

	localparam logic [WIDE_W-1:0] TERM_CAP = WIDE_W'(1) << (CAP_W - 1);

	logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic [LIMIT_W-1:0] pwm_limit_q;

	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic accept;

	acc_res_t res_s1;

	// Configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= GAIN_W'(131072);
			gain_i_q    <= GAIN_W'(1311);
			gain_d_q    <= '0;
			pwm_limit_q <= LIMIT_W'(1000);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_GAIN_P:    gain_p_q    <= cfg_wdata;
				REG_GAIN_I:    gain_i_q    <= cfg_wdata;
				REG_GAIN_D:    gain_d_q    <= cfg_wdata;
				REG_PWM_LIMIT: pwm_limit_q <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its content moves on.
	assign rdy5     = !v5_q || m_tready;
	assign rdy4     = !v4_q || rdy5;
	assign rdy3     = !v3_q || rdy4;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= s_tvalid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy5) v5_q <= v4_q;
		end
	end

	// Stage 1: error, difference, integral.
	pidsc_integrator u_integrator (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (accept),
		.speed_set      (s_tdata[15:0]),
		.measured_speed (s_tdata[31:16]),
		.res_s1         (res_s1)
	);

	// Stage 2: magnitudes times gains.
	logic [ERR_W-1:0]        emag;
	logic [DIFF_W-1:0]       dmag;
	logic [SUM_WIDTH-1:0]    smag;
	logic [P_W-1:0]          pmag;
	logic [D_W-1:0]          dprod;
	logic [HALF_W+GAIN_W-1:0] ilo;
	logic [HIGH_W+GAIN_W-1:0] ihi;
	logic [P_W-1:0]          pmag_s2;
	logic [D_W-1:0]          dmag_s2;
	logic [HALF_W+GAIN_W-1:0] ilo_s2;
	logic [HIGH_W+GAIN_W-1:0] ihi_s2;
	logic esign_s2, dsign_s2, isign_s2;

	assign emag  = res_s1.error[ERR_W-1] ? (~res_s1.error + 1'b1) : res_s1.error;
	assign dmag  = res_s1.diff[DIFF_W-1] ? (~res_s1.diff + 1'b1) : res_s1.diff;
	assign smag  = res_s1.sum[SUM_WIDTH-1] ? (~res_s1.sum + 1'b1) : res_s1.sum;
	assign pmag  = P_W'(emag) * P_W'(gain_p_q);
	assign dprod = D_W'(dmag) * D_W'(gain_d_q);
	assign ilo   = (HALF_W+GAIN_W)'(smag[HALF_W-1:0]) * (HALF_W+GAIN_W)'(gain_i_q);
	assign ihi   = (HIGH_W+GAIN_W)'(smag[SUM_WIDTH-1:HALF_W]) * (HIGH_W+GAIN_W)'(gain_i_q);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			pmag_s2  <= pmag;
			dmag_s2  <= dprod;
			ilo_s2   <= ilo;
			ihi_s2   <= ihi;
			esign_s2 <= res_s1.error[ERR_W-1];
			dsign_s2 <= res_s1.diff[DIFF_W-1];
			isign_s2 <= res_s1.sum[SUM_WIDTH-1];
		end
	end

	// Stage 3: integral product with cap; proportional plus derivative.
	logic [PROD_W-1:0] iprod;
	logic [WIDE_W-1:0] iprod_wide;
	logic [CAP_W-1:0]  icap;
	logic [PD_W-1:0]   pterm, dterm;
	logic [CAP_W-1:0]  imag_s3;
	logic              isign_s3;
	logic [PD_W-1:0]   pd_s3;

	assign iprod      = {ihi_s2, {HALF_W{1'b0}}} + {{HIGH_W{1'b0}}, ilo_s2};
	assign iprod_wide = WIDE_W'(iprod);
	assign icap       = (iprod_wide > TERM_CAP) ? TERM_CAP[CAP_W-1:0] : iprod_wide[CAP_W-1:0];
	assign pterm      = esign_s2 ? (~PD_W'(pmag_s2) + 1'b1) : PD_W'(pmag_s2);
	assign dterm      = dsign_s2 ? (~PD_W'(dmag_s2) + 1'b1) : PD_W'(dmag_s2);

	always_ff @(posedge clk) begin
		if (rdy3) begin
			imag_s3  <= icap;
			isign_s3 <= isign_s2;
			pd_s3    <= pterm + dterm;
		end
	end

	// Stage 4: signed sum of all terms, Q16.
	logic [TOT_W-1:0] iterm;
	logic [TOT_W-1:0] total_s4;

	assign iterm = isign_s3 ? (~TOT_W'(imag_s3) + 1'b1) : TOT_W'(imag_s3);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			total_s4 <= iterm + {{(TOT_W-PD_W){pd_s3[PD_W-1]}}, pd_s3};
		end
	end

	// Stage 5: truncate toward zero and clamp.
	logic [TOT_W-FRAC_W-1:0] whole;
	logic [LIMIT_W-1:0]      duty;
	logic                    clip;
	logic [LIMIT_W-1:0]      duty_s5;
	logic                    clip_s5;

	assign whole = total_s4[TOT_W-1:FRAC_W];

	always_comb begin
		if (total_s4[TOT_W-1]) begin
			duty = '0;
			// Values in (-1, 0) truncate to zero and are not flagged.
			clip = !((&whole) && (|total_s4[FRAC_W-1:0]));
		end else if (whole > (TOT_W-FRAC_W)'(pwm_limit_q)) begin
			duty = pwm_limit_q;
			clip = 1'b1;
		end else begin
			duty = whole[LIMIT_W-1:0];
			clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			duty_s5 <= duty;
			clip_s5 <= clip;
		end
	end

	assign m_tvalid = v5_q;
	assign m_tdata  = duty_s5;
	assign m_tuser  = clip_s5;

	`PIDSC_ASSERT_NOW(a_duty_limit, m_tvalid, m_tdata <= pwm_limit_q, "drive value above limit")
	`PIDSC_ASSERT_NOW(a_clip_value, m_tvalid && m_tuser, m_tdata == '0 || m_tdata == pwm_limit_q, "clamped drive value not at a bound")
	`PIDSC_ASSERT_NOW(a_full_stall, v1_q && v2_q && v3_q && v4_q && v5_q && !m_tready, !s_tready, "tick accepted into a full stalled pipeline")
	`PIDSC_ASSERT_NEXT(a_stage_fill, accept, v1_q, "accepted tick not held in the first stage")

endmodule

// ----- rtl/pidsc_integrator.sv -----
// Error, difference and saturating integral stage of the PID speed controller.
// Depends on pidsc_pkg and pid_speed_controller_macros.svh.
`include "pid_speed_controller_macros.svh"

module pidsc_integrator import pidsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [SPEED_W-1:0] speed_set,
	input  logic [SPEED_W-1:0] measured_speed,
	output acc_res_t           res_s1
);

	localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	logic [SUM_WIDTH-1:0] error_sum_q;
	logic [ERR_W-1:0]     last_error_q;
	logic [ERR_W-1:0]     error;
	logic [DIFF_W-1:0]    diff;
	logic [SUM_WIDTH:0]   sum_ext;
	logic [SUM_WIDTH-1:0] sum_next;

	assign error = {{(ERR_W-SPEED_W){speed_set[SPEED_W-1]}}, speed_set}
		- {{(ERR_W-SPEED_W){1'b0}}, measured_speed};
	assign diff = {error[ERR_W-1], error} - {last_error_q[ERR_W-1], last_error_q};

	// One guard bit shows an overflow, which then pins the sum to a bound.
	assign sum_ext = {error_sum_q[SUM_WIDTH-1], error_sum_q}
		+ {{(SUM_WIDTH+1-ERR_W){error[ERR_W-1]}}, error};

	always_comb begin
		if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
			sum_next = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_ext[SUM_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (load) begin
			error_sum_q  <= sum_next;
			last_error_q <= error;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1.error <= error;
			res_s1.diff  <= diff;
			res_s1.sum   <= sum_next;
		end
	end

	`PIDSC_ASSERT_NEXT(a_hold_state, !load, $stable(error_sum_q) && $stable(last_error_q), "integrator state changed without a transaction")
	`PIDSC_ASSERT_NEXT(a_last_error, load, last_error_q == $past(error), "previous error not stored")
	`PIDSC_ASSERT_NEXT(a_sat_high, load && error_sum_q == SUM_MAX && !error[ERR_W-1], error_sum_q == SUM_MAX, "integral left its upper bound on a non-negative error")
	`PIDSC_ASSERT_NEXT(a_sat_low, load && error_sum_q == SUM_MIN && (error[ERR_W-1] || error == '0), error_sum_q == SUM_MIN, "integral left its lower bound on a non-positive error")

endmodule

// ----- test/pid_speed_controller_test.sv -----
// Self-checking testbench for the PID speed controller top level.
// Depends on pidsc_pkg and the controller RTL; a scoreboard class predicts each drive value.
module pid_speed_controller_test;
	import pidsc_pkg::*;

	localparam longint unsigned TERM_CAP = 64'd1 << 60;
	localparam int TICKS_PER_PHASE = 160;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [15:0] duty;
		logic        clamped;
	} drive_t;

	class pid_drive_scoreboard;
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [LIMIT_W-1:0] duty_limit;
		longint             error_integral;
		int                 prev_error;
		drive_t             expected_drive_q[$];
		int unsigned        mismatches;

		function new();
			gain_p = 24'd131072;
			gain_i = 24'd1311;
			gain_d = 24'd0;
			duty_limit = 16'd1000;
			error_integral = 0;
			prev_error = 0;
			mismatches = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_GAIN_P:    gain_p = value;
				REG_GAIN_I:    gain_i = value;
				REG_GAIN_D:    gain_d = value;
				REG_PWM_LIMIT: duty_limit = value[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		// Signed value times an unsigned Q8.16 gain, magnitude capped at 2^60.
		function longint gain_term(longint v, logic [GAIN_W-1:0] gain);
			longint unsigned m;
			longint unsigned p;
			m = (v < 0) ? -v : v;
			if (gain == 0 || m == 0)
				return 0;
			if (m > TERM_CAP / gain)
				p = TERM_CAP;
			else
				p = m * gain;
			if (p > TERM_CAP)
				p = TERM_CAP;
			return (v < 0) ? -longint'(p) : longint'(p);
		endfunction

		function void note_tick(logic signed [15:0] target, logic [15:0] measured);
			int              err;
			int              diff;
			longint          smax;
			longint          smin;
			longint          total;
			longint unsigned mag;
			drive_t          d;
			err = int'(target) - int'(measured);
			diff = err - prev_error;
			smax = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
			smin = -smax - 1;
			if (err > 0 && error_integral > smax - err)
				error_integral = smax;
			else if (err < 0 && error_integral < smin - err)
				error_integral = smin;
			else
				error_integral += err;
			total = gain_term(err, gain_p) + gain_term(error_integral, gain_i)
				+ gain_term(diff, gain_d);
			mag = (total < 0) ? -total : total;
			mag = mag >> FRAC_W;
			// A raw value between -1 and 0 truncates to zero and is not a clamp.
			if (total < 0) begin
				d.duty = '0;
				d.clamped = (mag != 0);
			end else if (mag > duty_limit) begin
				d.duty = duty_limit;
				d.clamped = 1'b1;
			end else begin
				d.duty = mag[15:0];
				d.clamped = 1'b0;
			end
			prev_error = err;
			expected_drive_q.push_back(d);
		endfunction

		function void check_drive(logic [15:0] duty, logic clamped);
			drive_t exp_d;
			if (expected_drive_q.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result: duty %0d clamped %0b", duty, clamped);
				mismatches++;
				return;
			end
			exp_d = expected_drive_q.pop_front();
			if (duty !== exp_d.duty || clamped !== exp_d.clamped) begin
				if (mismatches < MAX_REPORTS)
					$display("drive mismatch: expected duty %0d clamped %0b, got duty %0d clamped %0b",
						exp_d.duty, exp_d.clamped, duty, clamped);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return expected_drive_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;   // [15:0] speed_set, [31:16] measured_speed
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;   // [15:0] pwm_duty
	logic                  m_tuser;   // [0] clamped

	pid_drive_scoreboard sb;
	bit src_idle_en;
	bit sink_idle_en;
	bit sink_hold_req;

	pid_speed_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Both handshakes are observed in one process so that a tick is always noted
	// before any result of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (s_tvalid && s_tready)
				sb.note_tick($signed(s_tdata[15:0]), s_tdata[31:16]);
			if (m_tvalid && m_tready)
				sb.check_drive(m_tdata, m_tuser);
		end
	end

	initial begin : sink_ready
		int unsigned n;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				m_tready <= 1'b0;
				for (n = 0; n < 400; n++)
					@(posedge clk);
				sink_hold_req = 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 99) < 8) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : watchdog
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
			input logic [GAIN_W-1:0] kd, input logic [LIMIT_W-1:0] limit);
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		// The upper data bits carry noise; the limit register keeps only 16 bits.
		write_reg(REG_PWM_LIMIT, {8'($urandom), limit});
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(input logic signed [15:0] target, input logic [15:0] measured);
		if (src_idle_en && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {measured, target};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Waiting for the clock first lets the monitor note the last accepted tick before the count is read.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] rand_gain(int top_bit);
		return GAIN_W'($urandom_range(0, (1 << top_bit) - 1));
	endfunction

	// Mostly closed-loop ticks with a small error around the target, steered so that
	// the integral stays near zero; the rest is full-range noise and corner values.
	task automatic send_random_tick();
		int                 kind;
		int                 err;
		int                 span;
		longint             pull;
		logic signed [15:0] t;
		logic [15:0]        m;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			t = 16'($urandom);
			m = 16'($urandom);
		end else if (kind < 22) begin
			case ($urandom_range(0, 3))
				0: t = 16'sh8000;
				1: t = 16'sh7fff;
				2: t = 16'sh0000;
				default: t = -16'sd1;
			endcase
			case ($urandom_range(0, 3))
				0: m = 16'h0000;
				1: m = 16'hffff;
				2: m = 16'h0001;
				default: m = 16'h8000;
			endcase
		end else begin
			if (sb.error_integral > 20000 || sb.error_integral < -20000) begin
				pull = sb.error_integral / 4;
				if (pull > 30000)
					pull = 30000;
				if (pull < -30000)
					pull = -30000;
				err = -int'(pull);
			end else begin
				span = 1 << $urandom_range(0, 11);
				err = int'($urandom_range(0, 2 * span)) - span;
			end
			if (err >= 0)
				t = 16'($urandom_range(32767, err));
			else
				t = 16'($urandom_range(32767, 0));
			m = 16'(int'(t) - err);
		end
		send_tick(t, m);
	endtask

	initial begin : stimulus
		int phase;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_GAIN_P;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		sink_hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset gains with the corner values of both fields.
		send_tick(16'sh0000, 16'h0000);
		send_tick(16'sh7fff, 16'h0000);
		send_tick(16'sh8000, 16'hffff);
		send_tick(16'sh7fff, 16'hffff);
		send_tick(16'sh8000, 16'h0000);
		send_tick(16'sh0000, 16'hffff);
		send_tick(-16'sd1, 16'h0000);
		send_tick(16'sd1000, 16'd500);
		send_tick(16'sd500, 16'd1000);
		send_tick(16'sd600, 16'd100);
		send_tick(16'sd600, 16'd600);

		// A tiny gain: a drive just below zero truncates to zero without a clamp.
		wait_drained();
		set_gains(24'd1, 24'd0, 24'd0, 16'hffff);
		send_tick(16'sd0, 16'd1);
		send_tick(16'sd1, 16'd0);
		send_tick(16'sh8000, 16'hffff);

		// Pure derivative action with a tight limit.
		wait_drained();
		set_gains(24'd0, 24'd0, 24'h010000, 16'd5);
		send_tick(16'sd10, 16'd0);
		send_tick(16'sd10, 16'd0);
		send_tick(16'sd0, 16'd10);

		// Largest gains against the largest error swing.
		wait_drained();
		set_gains(24'hffffff, 24'hffffff, 24'hffffff, 16'hffff);
		send_tick(16'sh8000, 16'hffff);
		send_tick(16'sh7fff, 16'h0000);
		send_tick(16'sh0000, 16'h0000);

		for (phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase)
				0: set_gains(24'd131072, 24'd1311, 24'd0, 16'd1000);
				1: set_gains(rand_gain(18), rand_gain(12), rand_gain(18), 16'($urandom));
				2: set_gains(24'hffffff, 24'hffffff, 24'hffffff, 16'd0);
				3: set_gains(24'd0, 24'd0, 24'd0, 16'($urandom));
				4: set_gains(rand_gain(24), rand_gain(24), rand_gain(24), 16'hffff);
				default: set_gains(rand_gain($urandom_range(4, 24)),
					rand_gain($urandom_range(4, 16)), rand_gain($urandom_range(4, 24)),
					16'($urandom));
			endcase
			if (phase == 1)
				sink_hold_req = 1'b1;
			if (phase == 5) begin
				src_idle_en = 1'b0;
				sink_idle_en = 1'b0;
			end
			repeat (TICKS_PER_PHASE) send_random_tick();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
